### hdl/hts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTML tag stripper package
// Beat types shared by the front parser, the entity decoder and the top level.
// ----------------------------------------------------------------------------
package hts_pkg;

    // Default depths of the parser-to-decoder queue and of the result queue.
    localparam int unsigned HTS_Q_DEPTH   = 4;
    localparam int unsigned HTS_OUT_DEPTH = 2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_final;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_text;
    } t_out_item;

    // One beat from the parser to the decoder: a visible text byte, a
    // flush request for the last byte of the document, or both.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_text;
        logic       is_final;
    } t_q_item;

endpackage : hts_pkg
`default_nettype wire

### hdl/hts_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTML tag stripper queue
// Small first-in first-out buffer with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module hts_fifo #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule : hts_fifo
`default_nettype wire

### hdl/hts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTML tag stripper front parser
// Tracks tags, quoted attributes and style/script raw content, and forwards
// visible text bytes and end-of-document flushes to the entity decoder.
// ----------------------------------------------------------------------------
module hts_front import hts_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_in_item,
    input  wire logic     i_q_full,
    output logic          o_full,
    output logic          o_q_push,
    output t_q_item       o_q_item
);

    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_DQ = 8'h22;
    localparam logic [7:0] CH_SQ = 8'h27;
    localparam logic [3:0] NAME_MAX = 4'd9;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_NAME,
        MODE_BODY,
        MODE_RAW
    } t_mode;

    function automatic logic [7:0] f_style_ch(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h73;
            4'd1:    ch = 8'h74;
            4'd2:    ch = 8'h79;
            4'd3:    ch = 8'h6C;
            4'd4:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] f_script_ch(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h73;
            4'd1:    ch = 8'h63;
            4'd2:    ch = 8'h72;
            4'd3:    ch = 8'h69;
            4'd4:    ch = 8'h70;
            4'd5:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Closing tag text: "</style>" when kind is 0, "</script>" when kind is 1.
    function automatic logic [7:0] f_close_ch(input logic kind, input logic [3:0] idx);
        logic [7:0] ch;
        if (idx == 4'd0) begin
            ch = CH_LT;
        end else if (idx == 4'd1) begin
            ch = 8'h2F;
        end else if (kind) begin
            ch = (idx == 4'd8) ? CH_GT : f_script_ch(idx - 4'd2);
        end else begin
            ch = (idx == 4'd7) ? CH_GT : f_style_ch(idx - 4'd2);
        end
        return ch;
    endfunction

    // Keeps only the flag of a name that matched a raw-content tag exactly.
    function automatic logic [1:0] f_end_name(input logic [3:0] len, input logic [1:0] alive);
        logic [1:0] res;
        if (len == 4'd5 && alive[0]) begin
            res = 2'b01;
        end else if (len == 4'd6 && alive[1]) begin
            res = 2'b10;
        end else begin
            res = 2'b00;
        end
        return res;
    endfunction

    t_mode      r_mode, n_mode;
    logic [3:0] r_name_len, n_name_len;
    logic [1:0] r_alive, n_alive;
    logic       r_raw_kind, n_raw_kind;
    logic       r_in_quote, n_in_quote;
    logic       r_quote_single, n_quote_single;
    logic [3:0] r_close_cnt, n_close_cnt;

    logic       accept;
    logic       text_out;
    logic [7:0] b;
    logic [7:0] lc;
    logic       is_space;
    logic [1:0] name_alive;
    logic [1:0] ended;
    logic [3:0] len_p1;
    logic [3:0] close_len;
    logic [3:0] close_p1;

    assign accept   = i_push && !i_q_full;
    assign o_full   = i_q_full;
    assign b        = i_in_item.text_byte;
    assign lc       = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    assign is_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    assign len_p1   = r_name_len + 4'd1;
    assign close_p1 = r_close_cnt + 4'd1;
    assign close_len = r_raw_kind ? 4'd9 : 4'd8;

    always_comb begin
        n_mode         = r_mode;
        n_name_len     = r_name_len;
        n_alive        = r_alive;
        n_raw_kind     = r_raw_kind;
        n_in_quote     = r_in_quote;
        n_quote_single = r_quote_single;
        n_close_cnt    = r_close_cnt;
        text_out       = 1'b0;
        name_alive     = r_alive;
        ended          = 2'b00;

        unique case (r_mode)
            MODE_TEXT: begin
                if (b == CH_LT) begin
                    n_mode         = MODE_NAME;
                    n_name_len     = 4'd0;
                    n_alive        = 2'b11;
                    n_in_quote     = 1'b0;
                    n_quote_single = 1'b0;
                end else begin
                    text_out = 1'b1;
                end
            end
            MODE_NAME: begin
                if (is_space) begin
                    n_alive = f_end_name(r_name_len, r_alive);
                    n_mode  = MODE_BODY;
                end else if (b == CH_GT) begin
                    ended   = f_end_name(r_name_len, r_alive);
                    n_alive = ended;
                    if (ended != 2'b00) begin
                        n_raw_kind  = ended[1];
                        n_close_cnt = 4'd0;
                        n_mode      = MODE_RAW;
                    end else begin
                        n_mode = MODE_TEXT;
                    end
                end else begin
                    if (!(r_name_len < 4'd5 && lc == f_style_ch(r_name_len))) begin
                        name_alive[0] = 1'b0;
                    end
                    if (!(r_name_len < 4'd6 && lc == f_script_ch(r_name_len))) begin
                        name_alive[1] = 1'b0;
                    end
                    n_name_len = len_p1;
                    if (len_p1 >= NAME_MAX) begin
                        n_alive = f_end_name(len_p1, name_alive);
                        n_mode  = MODE_BODY;
                    end else begin
                        n_alive = name_alive;
                    end
                end
            end
            MODE_BODY: begin
                if (!r_in_quote && (b == CH_DQ || b == CH_SQ)) begin
                    n_in_quote     = 1'b1;
                    n_quote_single = (b == CH_SQ);
                end else if (r_in_quote && b == (r_quote_single ? CH_SQ : CH_DQ)) begin
                    n_in_quote = 1'b0;
                end else if (!r_in_quote && b == CH_GT) begin
                    if (r_alive != 2'b00) begin
                        n_raw_kind  = (r_alive == 2'b10);
                        n_close_cnt = 4'd0;
                        n_mode      = MODE_RAW;
                    end else begin
                        n_mode = MODE_TEXT;
                    end
                end
            end
            MODE_RAW: begin
                if (r_close_cnt < close_len && b == f_close_ch(r_raw_kind, r_close_cnt)) begin
                    if (close_p1 >= close_len) begin
                        n_close_cnt = 4'd0;
                        n_mode      = MODE_TEXT;
                    end else begin
                        n_close_cnt = close_p1;
                    end
                end else begin
                    n_close_cnt = (b == CH_LT) ? 4'd1 : 4'd0;
                end
            end
            default: begin
                n_mode = MODE_TEXT;
            end
        endcase
    end

    assign o_q_push           = accept && (text_out || i_in_item.is_final);
    assign o_q_item.text_byte = b;
    assign o_q_item.is_text   = text_out;
    assign o_q_item.is_final  = i_in_item.is_final;

    // The last byte of a document returns the parser to its reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in_item.is_final)) begin
            r_mode         <= MODE_TEXT;
            r_name_len     <= 4'd0;
            r_alive        <= 2'b00;
            r_raw_kind     <= 1'b0;
            r_in_quote     <= 1'b0;
            r_quote_single <= 1'b0;
            r_close_cnt    <= 4'd0;
        end else if (accept) begin
            r_mode         <= n_mode;
            r_name_len     <= n_name_len;
            r_alive        <= n_alive;
            r_raw_kind     <= n_raw_kind;
            r_in_quote     <= n_in_quote;
            r_quote_single <= n_quote_single;
            r_close_cnt    <= n_close_cnt;
        end
    end

endmodule : hts_front
`default_nettype wire

### hdl/hts_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTML tag stripper entity decoder
// Holds a partial character entity, replaces complete ones, and plays out each
// beat from a small release buffer, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module hts_decode import hts_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_empty,
    input  wire t_q_item i_q_item,
    output logic         o_q_pop,
    input  wire logic    i_res_full,
    output logic         o_res_push,
    output t_out_item    o_res
);

    localparam int unsigned HOLD_DEPTH  = 5;
    localparam int unsigned ENT_NUM     = 6;
    localparam int unsigned ENT_MAX_LEN = 6;
    localparam int unsigned LIST_LEN    = 6;
    localparam logic [7:0]  CH_AMP      = 8'h26;

    // &amp; &lt; &gt; &quot; &apos; &nbsp;
    localparam logic [7:0] ENT_CH [ENT_NUM][ENT_MAX_LEN] = '{
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
        '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
        '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}
    };
    localparam logic [2:0] ENT_LEN [ENT_NUM] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6};
    localparam logic [7:0] ENT_VAL [ENT_NUM] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20};

    logic [7:0]         r_hold [HOLD_DEPTH];
    logic [2:0]         r_hcnt, n_hcnt;
    logic [ENT_NUM-1:0] r_alive, n_alive;
    t_out_item          r_eb [LIST_LEN];
    logic [2:0]         r_elen;

    logic               emit_go;
    logic               take;
    logic [7:0]         c;
    logic [2:0]         h;
    logic [2:0]         h_p1;
    logic [ENT_NUM-1:0] hit;
    logic [ENT_NUM-1:0] pref;
    logic               full_any;
    logic [7:0]         full_val;
    logic               single_val;
    logic               spill;
    logic               with_c;
    logic               hold_start;
    logic               hold_append;
    t_out_item          list [LIST_LEN];
    logic [2:0]         n_list;

    assign c       = i_q_item.text_byte;
    assign h       = r_hcnt;
    assign h_p1    = r_hcnt + 3'd1;
    assign emit_go = (r_elen != 3'd0) && !i_res_full;
    assign take    = !i_q_empty && ((r_elen == 3'd0) || (r_elen == 3'd1 && emit_go));
    assign o_q_pop    = take;
    assign o_res_push = emit_go;
    assign o_res      = r_eb[0];

    always_comb begin
        full_any = 1'b0;
        full_val = 8'h00;
        for (int e = ENT_NUM - 1; e >= 0; e--) begin
            hit[e]  = r_alive[e] && (c == ENT_CH[e][h]);
            pref[e] = hit[e] && (ENT_LEN[e] > h_p1);
            if (hit[e] && ENT_LEN[e] == h_p1) begin
                full_any = 1'b1;
                full_val = ENT_VAL[e];
            end
        end
    end

    // Classify the beat. A held sequence that can no longer become an entity
    // spills out unchanged; its tail holds no '&', so only the new byte can
    // start another entity.
    always_comb begin
        single_val  = 1'b0;
        spill       = 1'b0;
        with_c      = 1'b0;
        hold_start  = 1'b0;
        hold_append = 1'b0;
        if (!i_q_item.is_text) begin
            spill = 1'b1;
        end else if (h != 3'd0 && full_any) begin
            single_val = 1'b1;
        end else if (i_q_item.is_final) begin
            spill  = 1'b1;
            with_c = 1'b1;
        end else if (h == 3'd0) begin
            if (c == CH_AMP) begin
                hold_start = 1'b1;
            end else begin
                spill  = 1'b1;
                with_c = 1'b1;
            end
        end else if (pref != '0) begin
            hold_append = 1'b1;
        end else begin
            spill = 1'b1;
            if (c == CH_AMP) begin
                hold_start = 1'b1;
            end else begin
                with_c = 1'b1;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < LIST_LEN; k++) begin
            list[k] = '0;
        end
        n_list = 3'd0;
        if (single_val) begin
            list[0].out_byte   = full_val;
            list[0].byte_valid = 1'b1;
            n_list = 3'd1;
        end else if (spill) begin
            for (int k = 0; k < HOLD_DEPTH; k++) begin
                if (3'(k) < h) begin
                    list[k].out_byte   = r_hold[k];
                    list[k].byte_valid = 1'b1;
                end
            end
            for (int k = 0; k < LIST_LEN; k++) begin
                if (with_c && 3'(k) == h) begin
                    list[k].out_byte   = c;
                    list[k].byte_valid = 1'b1;
                end
            end
            n_list = h + {2'b00, with_c};
        end
        if (i_q_item.is_final) begin
            if (n_list == 3'd0) begin
                list[0].end_of_text = 1'b1;
                n_list = 3'd1;
            end else begin
                for (int k = 0; k < LIST_LEN; k++) begin
                    if (3'(k) == n_list - 3'd1) begin
                        list[k].end_of_text = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        n_hcnt  = r_hcnt;
        n_alive = r_alive;
        if (i_q_item.is_final) begin
            n_hcnt = 3'd0;
        end else if (hold_start) begin
            n_hcnt  = 3'd1;
            n_alive = '1;
        end else if (hold_append) begin
            n_hcnt  = h_p1;
            n_alive = pref;
        end else begin
            n_hcnt = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt <= 3'd0;
            r_elen <= 3'd0;
        end else begin
            if (take) begin
                r_hcnt <= n_hcnt;
                r_elen <= n_list;
            end else if (emit_go) begin
                r_elen <= r_elen - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_alive <= n_alive;
            if (!i_q_item.is_final && hold_start) begin
                r_hold[0] <= c;
            end else if (!i_q_item.is_final && hold_append) begin
                r_hold[h] <= c;
            end
            for (int k = 0; k < LIST_LEN; k++) begin
                r_eb[k] <= list[k];
            end
        end else if (emit_go) begin
            for (int k = 0; k < LIST_LEN - 1; k++) begin
                r_eb[k] <= r_eb[k + 1];
            end
        end
    end

endmodule : hts_decode
`default_nettype wire

### hdl/html_tag_strip_entity_decode_top.sv
// Path: beat queue, then decoder release buffer, then the result queue.
// Throughput: one byte per cycle while the beat queue has room; a byte that
// breaks a partial entity releases up to six results, one per cycle while the
// result queue has room, while the parser queue absorbs input.
// Reset: synchronous, active low; clears parser state, held entity, queues.
`default_nettype none
// ----------------------------------------------------------------------------
// HTML tag stripper with entity decoding, top level
// Front parser, beat queue, entity decoder and result queue.
// ----------------------------------------------------------------------------
module html_tag_strip_entity_decode_top import hts_pkg::*; #(
    parameter int unsigned Q_DEPTH   = HTS_Q_DEPTH,
    parameter int unsigned OUT_DEPTH = HTS_OUT_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_item  i_in_item,
    output logic           empty,
    input  wire logic      pop,
    output t_out_item      o_out_item
);

    localparam int unsigned Q_W   = $bits(t_q_item);
    localparam int unsigned OUT_W = $bits(t_out_item);

    logic             w_q_push;
    t_q_item          w_q_in;
    logic             w_q_full;
    logic             w_q_pop;
    logic [Q_W-1:0]   w_q_data;
    logic             w_q_empty;
    t_q_item          w_q_item;
    logic             w_res_push;
    t_out_item        w_res;
    logic             w_res_full;
    logic [OUT_W-1:0] w_out_data;

    assign w_q_item   = t_q_item'(w_q_data);
    assign o_out_item = t_out_item'(w_out_data);

    hts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_item (i_in_item),
        .i_q_full  (w_q_full),
        .o_full    (full),
        .o_q_push  (w_q_push),
        .o_q_item  (w_q_in)
    );

    hts_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    hts_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    hts_fifo #(
        .DATA_W (OUT_W),
        .DEPTH  (OUT_DEPTH)
    ) u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_out_data),
        .o_empty (empty)
    );

endmodule : html_tag_strip_entity_decode_top
`default_nettype wire

### hdl/hts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTML tag stripper port checker
// Watches the top level ports and flags malformed result beats.
// ----------------------------------------------------------------------------
module hts_checker import hts_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      full,
    input wire logic      empty,
    input wire logic      pop,
    input wire t_out_item o_out_item
);

    // A waiting result stays put until it is taken.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("result changed before it was taken");

    // A result without a character is only ever the end-of-document marker.
    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.byte_valid) |-> o_out_item.end_of_text)
        else $error("bare result without end marker");

    a_bare_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.byte_valid) |-> (o_out_item.out_byte == 8'h00))
        else $error("bare result carries a nonzero byte");

    // Reset drops every queued beat and reopens the input.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

endmodule : hts_checker

bind html_tag_strip_entity_decode_top hts_checker u_hts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);
`default_nettype wire
